### rtl/core/record_validator_with_crc32_macros.svh
// Assertion macros for the record validator. Each use names a label, an
// antecedent and a consequent; the clock is clk and the reset is rst in the
// scope of the use.
`ifndef RECORD_VALIDATOR_WITH_CRC32_MACROS_SVH
`define RECORD_VALIDATOR_WITH_CRC32_MACROS_SVH
`ifndef SYNTHESIS
`define RVCRC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");
`define RVCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");
`else
`define RVCRC_ASSERT_SAME(lbl, ante, cons)
`define RVCRC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/rvcrc_pkg.sv
`timescale 1ns / 1ps
package rvcrc_pkg;

  // Default record geometry.
  localparam int SERIAL_BYTES_DEF  = 16;
  localparam int ADDRESS_BYTES_DEF = 6;
  localparam int PEER_SLOTS_DEF    = 2;
  localparam int KEY_BYTES_DEF     = 16;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;

  // Configuration port.
  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W  = 16;
  localparam logic [REG_INDEX_W-1:0] REG_MAGIC   = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_VERSION = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_ROLE_A  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_ROLE_B  = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_ROLE_C  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_CRC     = 3'd3,
    ST_SERIAL  = 3'd4,
    ST_ROLE    = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] magic_value;
    logic [15:0] version_value;
    logic [7:0]  role_code_a;
    logic [7:0]  role_code_b;
    logic [7:0]  role_code_c;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] role_byte;
  } result_t;

  // One byte of reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/rvcrc_byte_if.sv
`timescale 1ns / 1ps
interface rvcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/core/rvcrc_result_if.sv
`timescale 1ns / 1ps
interface rvcrc_result_if;
  logic               valid;
  logic               ready;
  rvcrc_pkg::status_t status;
  logic [7:0]         role_byte;

  modport source (output valid, output status, output role_byte, input ready);
  modport sink (input valid, input status, input role_byte, output ready);
endinterface

### rtl/core/rvcrc_check.sv
`timescale 1ns / 1ps
module rvcrc_check #(
  parameter int SERIAL_BYTES  = rvcrc_pkg::SERIAL_BYTES_DEF,
  parameter int ADDRESS_BYTES = rvcrc_pkg::ADDRESS_BYTES_DEF,
  parameter int PEER_SLOTS    = rvcrc_pkg::PEER_SLOTS_DEF,
  parameter int KEY_BYTES     = rvcrc_pkg::KEY_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  rvcrc_pkg::cfg_t    cfg,
  output logic               last,
  output rvcrc_pkg::result_t result
);

  localparam int POS_SERIAL   = 4;
  localparam int POS_ROLE     = POS_SERIAL + SERIAL_BYTES;
  localparam int POS_CRC      = POS_ROLE + 1 + ADDRESS_BYTES * (1 + PEER_SLOTS) + KEY_BYTES;
  localparam int RECORD_BYTES = POS_CRC + 4;
  localparam int POS_W        = $clog2(RECORD_BYTES);

  logic [POS_W-1:0] byte_position;
  logic [31:0]      crc_accumulator;
  logic             magic_bad;
  logic             version_bad;
  logic             crc_bad;
  logic             serial_ended;
  logic             serial_has_char;
  logic             serial_bad;
  logic [7:0]       held_role;

  logic [31:0]      crc_accumulator_next;
  logic             magic_bad_next;
  logic             version_bad_next;
  logic             crc_bad_next;
  logic             serial_ended_next;
  logic             serial_has_char_next;
  logic             serial_bad_next;
  logic [7:0]       held_role_next;
  logic [31:0]      final_crc;
  logic [POS_W-1:0] crc_offset;
  logic [7:0]       crc_expected;
  logic             char_ok;
  logic             role_ok;

  assign final_crc  = ~crc_accumulator;
  assign crc_offset = byte_position - POS_W'(POS_CRC);
  assign last       = (byte_position == POS_W'(RECORD_BYTES - 1));
  assign char_ok    = (data_byte >= rvcrc_pkg::CHAR_UPPER_A && data_byte <= rvcrc_pkg::CHAR_UPPER_Z)
                   || (data_byte >= rvcrc_pkg::CHAR_DIGIT_0 && data_byte <= rvcrc_pkg::CHAR_DIGIT_9)
                   || (data_byte == rvcrc_pkg::CHAR_DASH);

  always_comb begin
    case (crc_offset[1:0])
      2'd0:    crc_expected = final_crc[7:0];
      2'd1:    crc_expected = final_crc[15:8];
      2'd2:    crc_expected = final_crc[23:16];
      default: crc_expected = final_crc[31:24];
    endcase
  end

  always_comb begin
    crc_accumulator_next = crc_accumulator;
    magic_bad_next       = magic_bad;
    version_bad_next     = version_bad;
    crc_bad_next         = crc_bad;
    serial_ended_next    = serial_ended;
    serial_has_char_next = serial_has_char;
    serial_bad_next      = serial_bad;
    held_role_next       = held_role;

    if (byte_position == POS_W'(0) && data_byte != cfg.magic_value[7:0]) begin
      magic_bad_next = 1'b1;
    end
    if (byte_position == POS_W'(1) && data_byte != cfg.magic_value[15:8]) begin
      magic_bad_next = 1'b1;
    end
    if (byte_position == POS_W'(2) && data_byte != cfg.version_value[7:0]) begin
      version_bad_next = 1'b1;
    end
    if (byte_position == POS_W'(3) && data_byte != cfg.version_value[15:8]) begin
      version_bad_next = 1'b1;
    end

    if (byte_position < POS_W'(POS_CRC)) begin
      crc_accumulator_next = rvcrc_pkg::crc32_byte(crc_accumulator, data_byte);
    end else if (data_byte != crc_expected) begin
      crc_bad_next = 1'b1;
    end

    if (byte_position >= POS_W'(POS_SERIAL) && byte_position < POS_W'(POS_ROLE)) begin
      if (serial_ended) begin
        if (data_byte != 8'd0) begin
          serial_bad_next = 1'b1;
        end
      end else if (data_byte == 8'd0) begin
        serial_ended_next = 1'b1;
      end else if (!char_ok) begin
        serial_bad_next = 1'b1;
      end else begin
        serial_has_char_next = 1'b1;
      end
    end

    if (byte_position == POS_W'(POS_ROLE)) begin
      held_role_next = data_byte;
    end
  end

  assign role_ok = (held_role_next == cfg.role_code_a) || (held_role_next == cfg.role_code_b)
                || (held_role_next == cfg.role_code_c);

  always_comb begin
    if (magic_bad_next) begin
      result.status = rvcrc_pkg::ST_MAGIC;
    end else if (version_bad_next) begin
      result.status = rvcrc_pkg::ST_VERSION;
    end else if (crc_bad_next) begin
      result.status = rvcrc_pkg::ST_CRC;
    end else if (serial_bad_next || !serial_has_char_next) begin
      result.status = rvcrc_pkg::ST_SERIAL;
    end else if (!role_ok) begin
      result.status = rvcrc_pkg::ST_ROLE;
    end else begin
      result.status = rvcrc_pkg::ST_OK;
    end
    result.role_byte = (result.status == rvcrc_pkg::ST_OK) ? held_role_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_position   <= '0;
      crc_accumulator <= rvcrc_pkg::CRC_INIT;
      magic_bad       <= 1'b0;
      version_bad     <= 1'b0;
      crc_bad         <= 1'b0;
      serial_ended    <= 1'b0;
      serial_has_char <= 1'b0;
      serial_bad      <= 1'b0;
      held_role       <= 8'd0;
    end else if (step) begin
      byte_position   <= byte_position + POS_W'(1);
      crc_accumulator <= crc_accumulator_next;
      magic_bad       <= magic_bad_next;
      version_bad     <= version_bad_next;
      crc_bad         <= crc_bad_next;
      serial_ended    <= serial_ended_next;
      serial_has_char <= serial_has_char_next;
      serial_bad      <= serial_bad_next;
      held_role       <= held_role_next;
    end
  end

endmodule

### rtl/core/record_validator_with_crc32.sv
`timescale 1ns / 1ps
// Provisioning record validator. The block takes a fixed-size record one byte
// per transaction on data_ch: a little-endian 16-bit magic and version, the
// serial text, a role byte, own and peer addresses, a key and a little-endian
// CRC-32 (reflected, polynomial 0xEDB88320, init and final xor all ones) over
// every byte but the last four. After the final byte it returns one
// transaction on result_ch whose status is, first match winning: magic,
// version, crc, serial, role error, else ok; role_byte carries the role only
// when the status is ok. It sustains one byte per clock cycle; a byte is held
// in the input register until it advances into the checker, and processing
// the final byte loads the result into the output register. The cycle is
// bounded by the eight-step CRC-32 byte update that runs between the input
// register and the running CRC register of the checker. The input keeps
// accepting bytes while a result waits to be taken, and only the final byte of
// the next record stalls until the output register is free. Configuration
// registers (magic, version, three role codes) are written through
// write_enable, reg_index and write_data, and must only change while no record is in flight.
module record_validator_with_crc32 #(
  parameter int SERIAL_BYTES  = rvcrc_pkg::SERIAL_BYTES_DEF,
  parameter int ADDRESS_BYTES = rvcrc_pkg::ADDRESS_BYTES_DEF,
  parameter int PEER_SLOTS    = rvcrc_pkg::PEER_SLOTS_DEF,
  parameter int KEY_BYTES     = rvcrc_pkg::KEY_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [rvcrc_pkg::REG_INDEX_W-1:0]   reg_index,
  input  logic [rvcrc_pkg::REG_DATA_W-1:0]    write_data,
  rvcrc_byte_if.sink                          data_ch,
  rvcrc_result_if.source                      result_ch
);

`include "record_validator_with_crc32_macros.svh"

  // Configuration registers, gathered into one struct for the checker.
  rvcrc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_value   <= 16'd0;
      cfg.version_value <= 16'd1;
      cfg.role_code_a   <= 8'd0;
      cfg.role_code_b   <= 8'd1;
      cfg.role_code_c   <= 8'd2;
    end else if (write_enable) begin
      case (reg_index)
        rvcrc_pkg::REG_MAGIC:   cfg.magic_value   <= write_data;
        rvcrc_pkg::REG_VERSION: cfg.version_value <= write_data;
        rvcrc_pkg::REG_ROLE_A:  cfg.role_code_a   <= write_data[7:0];
        rvcrc_pkg::REG_ROLE_B:  cfg.role_code_b   <= write_data[7:0];
        rvcrc_pkg::REG_ROLE_C:  cfg.role_code_c   <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register. A held byte advances into the checker unless it is the
  // final byte of a record and the output register is still occupied.
  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  logic               last;
  rvcrc_pkg::result_t result_now;

  logic               out_valid;
  rvcrc_pkg::result_t out_result;

  assign advance       = in_valid && (!last || !out_valid || result_ch.ready);
  assign data_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (data_ch.ready) begin
      in_valid <= data_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ch.ready && data_ch.valid) begin
      in_byte <= data_ch.data_byte;
    end
  end

  // Field checks, running CRC and the record position live in the checker;
  // it also forms the status that the final byte would produce.
  rvcrc_check #(
    .SERIAL_BYTES  (SERIAL_BYTES),
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .PEER_SLOTS    (PEER_SLOTS),
    .KEY_BYTES     (KEY_BYTES)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .cfg       (cfg),
    .last      (last),
    .result    (result_now)
  );

  // Output register. It loads when the final byte of a record is processed
  // and empties when the downstream side takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      out_result <= result_now;
    end
  end

  assign result_ch.valid     = out_valid;
  assign result_ch.status    = out_result.status;
  assign result_ch.role_byte = out_result.role_byte;

  // An error status never reports a role.
  `RVCRC_ASSERT_SAME(a_role_zero_on_error, result_ch.valid && result_ch.status != rvcrc_pkg::ST_OK, result_ch.role_byte == 8'd0)
  // Processing the final byte always leaves a result waiting.
  `RVCRC_ASSERT_NEXT(a_result_loaded, !rst && advance && last, result_ch.valid)
  // A held byte that cannot advance is neither lost nor overwritten.
  `RVCRC_ASSERT_NEXT(a_input_held, !rst && in_valid && !advance, in_valid && $stable(in_byte))

endmodule
